// ===== hdl/bmes_pkg.sv =====
// Shared constants, command codes and controller/datapath handshake types
// for the batch median EMA smoother. No dependencies.
package bmes_pkg;

   localparam int BATCH_SIZE = 8;
   localparam int IDX_W      = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
   localparam int CNT_W      = $clog2(BATCH_SIZE + 1);

   localparam int RTT_W      = 12;
   localparam int LAT_W      = 11;
   localparam int BATCH_W    = 16;
   localparam int FRAC_W     = 8;
   localparam int EMA_W      = LAT_W + FRAC_W;
   localparam int ALPHA_W    = 9;
   localparam int PROD_W     = ALPHA_W + EMA_W;
   localparam int ACC_W      = EMA_W + ALPHA_W + 1;
   localparam int CMD_W      = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(77);
   localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(256);

   localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   typedef struct packed {
      logic take;
      logic scan;
      logic mul_new;
      logic mul_old;
      logic sum;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_median;
      logic scan_done;
      logic slot_free;
   } ctl_status_type;

endpackage

// ===== hdl/batch_median_ema_smoother_top.sv =====
// Item without a result (failed, dropped, restart, short tick): accepted
// and finished in ST_IDLE. Item with a result: n = samples in the batch (1..8); the
// rank scan visits one stored sample a cycle, then the shared 9x19 multiplier
// forms the new term and then the old term, an add forms the average, and the
// result register is loaded once the rsp side has a free slot.
// Reset (sync, high): clears count, batch counter, average, alpha to 77.
module batch_median_ema_smoother_top
   import bmes_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] rtt_ms, [15:12] zero
   input  logic [CMD_W-1:0]      req_tuser,   // [1:0] command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [10:0] latency_ms, [26:11] batch_number
   output logic                  rsp_tuser,   // [0] is_batch_result
   input  logic                  csr_we,
   input  logic [ALPHA_W-1:0]    csr_wdata    // alpha_q8
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   bmes_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bmes_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ===== hdl/bmes_ctrl.sv =====
// Sequencing state machine for the batch median EMA smoother.
// Depends on bmes_pkg for the command and status structs.
module bmes_ctrl
   import bmes_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_SCAN    = 6'b000010,
      ST_MUL_NEW = 6'b000100,
      ST_MUL_OLD = 6'b001000,
      ST_SUM     = 6'b010000,
      ST_OUT     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd         = '0;
      cmd.take    = req_tvalid && req_tready;
      cmd.scan    = (state_ff == ST_SCAN);
      cmd.mul_new = (state_ff == ST_MUL_NEW);
      cmd.mul_old = (state_ff == ST_MUL_OLD);
      cmd.sum     = (state_ff == ST_SUM);
      cmd.emit    = (state_ff == ST_OUT) && status.slot_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.take && status.need_median) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_MUL_NEW;
         end
         ST_MUL_NEW: state_in = ST_MUL_OLD;
         ST_MUL_OLD: state_in = ST_SUM;
         ST_SUM:     state_in = ST_OUT;
         ST_OUT: begin
            if (status.slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/bmes_dp.sv =====
// Datapath: sample store, rank scan, shared EMA multiplier, result register.
// Depends on bmes_pkg; driven by bmes_ctrl through command/status structs.
module bmes_dp
   import bmes_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic                  csr_we,
   input  logic [ALPHA_W-1:0]    csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   input  ctl_cmd_type           cmd,
   output ctl_status_type        status
);

   logic [LAT_W-1:0]   store_ff [BATCH_SIZE];
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [BATCH_W-1:0] batch_ff;
   logic [BATCH_W-1:0] bnum_ff;
   logic               is_batch_ff;
   logic [LAT_W-1:0]   median_ff;
   logic               found_ff;
   logic [EMA_W-1:0]   ema_ff;
   logic               loaded_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic               rsp_valid_ff;
   logic [LAT_W-1:0]   rsp_lat_ff;
   logic [BATCH_W-1:0] rsp_bnum_ff;
   logic               rsp_batch_ff;

   logic [RTT_W-1:0]   rtt;
   logic               sample_ok;
   logic               tick_full;
   logic [CNT_W-1:0]   cnt_next;
   logic [LAT_W-1:0]   cand;
   logic [CNT_W-1:0]   lt_cnt;
   logic [CNT_W-1:0]   le_cnt;
   logic [CNT_W-1:0]   rank;
   logic [ALPHA_W-1:0] alpha_eff;
   logic [ALPHA_W-1:0] mul_a;
   logic [EMA_W-1:0]   mul_b;
   logic [EMA_W:0]     ema_round;

   assign rtt       = req_tdata[RTT_W-1:0];
   assign cnt_next  = cnt_ff + CNT_W'(1);
   assign sample_ok = (req_tuser == CMD_SAMPLE) && !rtt[RTT_W-1] && (rtt != '0)
                      && (cnt_ff < CNT_W'(BATCH_SIZE));
   assign tick_full = (req_tuser == CMD_TICK) && (cnt_ff == CNT_W'(BATCH_SIZE));

   assign status.need_median = (sample_ok && (batch_ff == '0)
                                && (cnt_next < CNT_W'(BATCH_SIZE))) || tick_full;
   assign status.scan_done   = (CNT_W'(idx_ff) == n_ff - CNT_W'(1));
   assign status.slot_free   = !rsp_valid_ff || rsp_tready;

   // rank of the candidate among the live entries
   assign cand = store_ff[idx_ff];
   assign rank = n_ff >> 1;
   always_comb begin
      lt_cnt = '0;
      le_cnt = '0;
      for (int j = 0; j < BATCH_SIZE; j++) begin
         if (CNT_W'(j) < n_ff) begin
            if (store_ff[j] < cand)  lt_cnt = lt_cnt + CNT_W'(1);
            if (store_ff[j] <= cand) le_cnt = le_cnt + CNT_W'(1);
         end
      end
   end

   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign mul_a     = cmd.mul_old ? (ALPHA_ONE - alpha_eff) : alpha_eff;
   assign mul_b     = cmd.mul_old ? ema_ff : EMA_W'(median_ff);
   assign ema_round = {1'b0, ema_ff} + (EMA_W + 1)'(1 << (FRAC_W - 1));

   always_ff @(posedge clock) begin
      if (cmd.take && sample_ok) store_ff[cnt_ff[IDX_W-1:0]] <= rtt[LAT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         n_ff        <= sample_ok ? cnt_next : cnt_ff;
         is_batch_ff <= tick_full;
         bnum_ff     <= tick_full ? batch_ff : '0;
         idx_ff      <= '0;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.scan && (lt_cnt <= rank) && (rank < le_cnt)) median_ff <= cand;
      if (cmd.mul_new) prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      if (cmd.mul_old) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
         acc_ff  <= ACC_W'({prod_ff, FRAC_W'(0)}) + ACC_W'(1 << (FRAC_W - 1));
      end
      if (cmd.emit) begin
         rsp_lat_ff   <= ema_round[FRAC_W +: LAT_W];
         rsp_bnum_ff  <= bnum_ff;
         rsp_batch_ff <= is_batch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         batch_ff     <= '0;
         ema_ff       <= '0;
         loaded_ff    <= 1'b0;
         alpha_ff     <= ALPHA_RESET;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) alpha_ff <= csr_wdata;
         if (cmd.take) begin
            found_ff <= 1'b0;
            if (sample_ok) cnt_ff <= cnt_next;
            if (tick_full) begin
               cnt_ff <= '0;
               if (batch_ff != '1) batch_ff <= batch_ff + BATCH_W'(1);
            end
            if (req_tuser == CMD_RESTART) begin
               cnt_ff    <= '0;
               batch_ff  <= '0;
               ema_ff    <= '0;
               loaded_ff <= 1'b0;
            end
         end
         if (cmd.scan && (lt_cnt <= rank) && (rank < le_cnt)) found_ff <= 1'b1;
         if (cmd.sum) begin
            loaded_ff <= 1'b1;
            if (loaded_ff) ema_ff <= EMA_W'((acc_ff + ACC_W'(prod_ff)) >> FRAC_W);
            else           ema_ff <= {median_ff, FRAC_W'(0)};
         end
         if (cmd.emit)          rsp_valid_ff <= 1'b1;
         else if (rsp_tready)   rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_batch_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_bnum_ff, rsp_lat_ff});

   a_found_before_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_new |-> found_ff)
      else $error("median not found by end of scan");

   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && tick_full) |=> (cnt_ff == '0))
      else $error("batch tick did not clear the store count");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted result not presented");

endmodule
